// File: src/cmap_pkg.sv
// ----------------------------------------------------------------------------
// cmap_pkg
// Types and constants shared by the iteration-count colour map.
// ----------------------------------------------------------------------------
`default_nettype none

package cmap_pkg;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_NEW_LOG = 2'd1,
        MODE_OLD_LOG = 2'd2,
        MODE_SQRT    = 2'd3
    } t_mode;

    localparam logic [1:0] REG_MAP_MODE = 2'd0;
    localparam logic [1:0] REG_RANGES   = 2'd1;
    localparam logic [1:0] REG_OFFSET   = 2'd2;
    localparam logic [1:0] REG_SCALE    = 2'd3;

    localparam int OFFSET_W  = 24;
    localparam int SCALE_W   = 32;
    localparam int RESULT_W  = 24;
    localparam int OP_W      = 32;            // internal operand width
    localparam int LOG_FRAC  = 24;            // log2 fraction bits
    localparam int LOG2_W    = 5 + LOG_FRAC;  // Q5.24
    localparam int LN_W      = 21;            // ln in Q5.16
    localparam int SQ_STEPS  = 32;            // one result bit per stage
    localparam int LOG_PAD   = SQ_STEPS - LOG_FRAC - 2;

    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    typedef struct packed {
        t_mode mode;
        logic  force_one;   // result is colour one
        logic  zero_out;    // mode none with ranges in use
    } t_ctl;

endpackage

`default_nettype wire

// File: src/cmap_log_stage.sv
// ----------------------------------------------------------------------------
// cmap_log_stage
// One fraction bit of log2: square the mantissa, halve on overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module cmap_log_stage (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [31:0]                   i_m,
    input  wire logic [cmap_pkg::LOG_FRAC-1:0] i_frac,
    input  wire logic [4:0]                    i_n,
    output logic      [31:0]                   o_m,
    output logic      [cmap_pkg::LOG_FRAC-1:0] o_frac,
    output logic      [4:0]                    o_n
);
    import cmap_pkg::*;

    logic [63:0]         w_sq;
    logic [32:0]         w_t;
    logic [31:0]         n_m;
    logic [LOG_FRAC-1:0] n_frac;
    logic [31:0]         r_m;
    logic [LOG_FRAC-1:0] r_frac;
    logic [4:0]          r_n;

    always_comb begin
        w_sq = i_m * i_m;
        w_t  = w_sq[63:31];
        if (w_t[32]) begin
            n_m    = w_t[32:1];
            n_frac = {i_frac[LOG_FRAC-2:0], 1'b1};
        end else begin
            n_m    = w_t[31:0];
            n_frac = {i_frac[LOG_FRAC-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_m;
            r_frac <= n_frac;
            r_n    <= i_n;
        end
    end

    assign o_m    = r_m;
    assign o_frac = r_frac;
    assign o_n    = r_n;

endmodule

`default_nettype wire

// File: src/cmap_sqrt_stage.sv
// ----------------------------------------------------------------------------
// cmap_sqrt_stage
// One step of the restoring square root; also carries the item's control.
// ----------------------------------------------------------------------------
`default_nettype none

module cmap_sqrt_stage #(
    parameter int STEP = 0
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire cmap_pkg::t_ctl            i_ctl,
    input  wire logic [cmap_pkg::OP_W-1:0] i_x,
    input  wire logic [63:0]               i_v,
    input  wire logic [63:0]               i_res,
    output logic                           o_valid,
    output cmap_pkg::t_ctl                 o_ctl,
    output logic      [cmap_pkg::OP_W-1:0] o_x,
    output logic      [63:0]               o_v,
    output logic      [63:0]               o_res
);
    import cmap_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0] w_trial;
    logic [63:0] n_v;
    logic [63:0] n_res;
    logic        r_valid;
    t_ctl        r_ctl;
    logic [OP_W-1:0] r_x;
    logic [63:0] r_v;
    logic [63:0] r_res;

    always_comb begin
        w_trial = i_res | BIT;
        if (i_v >= w_trial) begin
            n_v   = i_v - w_trial;
            n_res = (i_res >> 1) | BIT;
        end else begin
            n_v   = i_v;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_x   <= i_x;
            r_v   <= n_v;
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_x     = r_x;
    assign o_v     = r_v;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: src/iteration_count_log_color_map_top.sv
// ----------------------------------------------------------------------------
// iteration_count_log_color_map_top
// Maps a pixel's iteration count to a palette index (none, log, sqrt modes).
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake           Payload
// input     in   i_valid / o_stall   i_iter_count
// output    out  o_valid / i_stall   o_color_index
// config    in   i_cfg_we            i_cfg_idx, i_cfg_data
//
// One count per cycle while the pipeline is not held. Stages: front stage,
// 32 square-root steps (log2 runs alongside: normalise, 24 squarings, ln
// multiply, padding), scale multiply, output register.
// The whole pipeline advances together; it holds while the output register
// is full and stalled. Reset clears the config and all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module iteration_count_log_color_map_top #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_idx,
    input  wire logic [31:0]                   i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [COUNT_BITS-1:0]         i_iter_count,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [COUNT_BITS-1:0]         o_color_index
);
    import cmap_pkg::*;

    localparam logic [32:0] SAT_MAX = 33'((33'd1 << COUNT_BITS) - 33'd1);

    // configuration
    t_mode               r_mode;
    logic                r_ranges;
    logic [OFFSET_W-1:0] r_offset;
    logic [SCALE_W-1:0]  r_scale;
    logic [31:0]         r_scale_sq_hi;
    logic [63:0]         w_scale_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_NONE;
            r_ranges      <= 1'b0;
            r_offset      <= '0;
            r_scale       <= '0;
            r_scale_sq_hi <= '0;
        end else begin
            r_scale_sq_hi <= w_scale_sq[63:32];
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MAP_MODE: r_mode   <= t_mode'(i_cfg_data[1:0]);
                    REG_RANGES:   r_ranges <= i_cfg_data[0];
                    REG_OFFSET:   r_offset <= i_cfg_data[OFFSET_W-1:0];
                    REG_SCALE:    r_scale  <= i_cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    assign w_scale_sq = r_scale * r_scale;

    // global advance
    logic w_en;
    logic r_out_valid;
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    // front stage: offset, special cases
    logic [OP_W-1:0] w_c;
    logic [32:0]     w_c33;
    logic [32:0]     w_off33;
    t_ctl            n_s0_ctl;
    logic [OP_W-1:0] n_s0_x;
    logic            r_s0_valid;
    t_ctl            r_s0_ctl;
    logic [OP_W-1:0] r_s0_x;

    always_comb begin
        w_c     = OP_W'(i_iter_count);
        w_c33   = 33'(w_c);
        w_off33 = 33'(r_offset);
        n_s0_ctl.mode     = r_mode;
        n_s0_ctl.zero_out = r_ranges;
        unique case (r_mode)
            MODE_NEW_LOG: n_s0_ctl.force_one = (w_c33 <= w_off33 + 33'd1);
            MODE_OLD_LOG: n_s0_ctl.force_one = (w_c == '0);
            MODE_SQRT:    n_s0_ctl.force_one = (w_c33 <= w_off33);
            default:      n_s0_ctl.force_one = 1'b0;
        endcase
        if (r_mode == MODE_NONE || r_mode == MODE_OLD_LOG) begin
            n_s0_x = w_c;
        end else begin
            n_s0_x = w_c - OP_W'(r_offset);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_ctl <= n_s0_ctl;
            r_s0_x   <= n_s0_x;
        end
    end

    // log2: leading-one normalisation
    logic [4:0]  n_l_n;
    logic [31:0] n_l_m;
    logic [4:0]  r_l_n;
    logic [31:0] r_l_m;

    always_comb begin
        n_l_n = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_s0_x[i]) begin
                n_l_n = 5'(i);
            end
        end
        n_l_m = r_s0_x << (5'd31 - n_l_n);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l_n <= n_l_n;
            r_l_m <= n_l_m;
        end
    end

    // log2: squaring chain
    logic [31:0]         w_m    [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] w_frac [0:LOG_FRAC];
    logic [4:0]          w_n    [0:LOG_FRAC];

    assign w_m[0]    = r_l_m;
    assign w_frac[0] = '0;
    assign w_n[0]    = r_l_n;

    for (genvar g = 0; g < LOG_FRAC; g++) begin : g_log
        cmap_log_stage u_log_stage (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_m    (w_m[g]),
            .i_frac (w_frac[g]),
            .i_n    (w_n[g]),
            .o_m    (w_m[g+1]),
            .o_frac (w_frac[g+1]),
            .o_n    (w_n[g+1])
        );
    end

    // ln = log2 * ln2
    logic [LOG2_W-1:0] w_log2;
    logic [60:0]       w_ln_prod;
    logic [LN_W-1:0]   r_lq;
    logic [LN_W-1:0]   r_lq_dly [0:LOG_PAD-1];

    assign w_log2    = {w_n[LOG_FRAC], w_frac[LOG_FRAC]};
    assign w_ln_prod = 61'(w_log2) * 61'(LN2_Q32);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lq        <= w_ln_prod[60:40];
            r_lq_dly[0] <= r_lq;
            for (int i = 1; i < LOG_PAD; i++) begin
                r_lq_dly[i] <= r_lq_dly[i-1];
            end
        end
    end

    // square root chain, carries valid, control and operand
    logic            w_q_valid [0:SQ_STEPS];
    t_ctl            w_q_ctl   [0:SQ_STEPS];
    logic [OP_W-1:0] w_q_x     [0:SQ_STEPS];
    logic [63:0]     w_q_v     [0:SQ_STEPS];
    logic [63:0]     w_q_res   [0:SQ_STEPS];

    assign w_q_valid[0] = r_s0_valid;
    assign w_q_ctl[0]   = r_s0_ctl;
    assign w_q_x[0]     = r_s0_x;
    assign w_q_v[0]     = {r_s0_x, 32'd0};
    assign w_q_res[0]   = '0;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        cmap_sqrt_stage #(.STEP(g)) u_sqrt_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_q_valid[g]),
            .i_ctl   (w_q_ctl[g]),
            .i_x     (w_q_x[g]),
            .i_v     (w_q_v[g]),
            .i_res   (w_q_res[g]),
            .o_valid (w_q_valid[g+1]),
            .o_ctl   (w_q_ctl[g+1]),
            .o_x     (w_q_x[g+1]),
            .o_v     (w_q_v[g+1]),
            .o_res   (w_q_res[g+1])
        );
    end

    // scale multiply
    logic [31:0]     w_op;
    logic            r_b1_valid;
    t_ctl            r_b1_ctl;
    logic [OP_W-1:0] r_b1_x;
    logic [63:0]     r_b1_p;

    assign w_op = (w_q_ctl[SQ_STEPS].mode == MODE_SQRT) ? w_q_res[SQ_STEPS][31:0]
                                                        : 32'(r_lq_dly[LOG_PAD-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (w_en) begin
            r_b1_valid <= w_q_valid[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_ctl <= w_q_ctl[SQ_STEPS];
            r_b1_x   <= w_q_x[SQ_STEPS];
            r_b1_p   <= r_scale * w_op;
        end
    end

    // result select and saturation
    logic [31:0]           w_hi;
    logic [32:0]           w_hi1;
    logic [32:0]           w_x33;
    logic [32:0]           w_r;
    logic [32:0]           w_sat;
    logic [COUNT_BITS-1:0] r_color;

    always_comb begin
        w_hi  = r_b1_p[63:32];
        w_hi1 = 33'(w_hi) + 33'd1;
        w_x33 = 33'(r_b1_x);
        priority if (r_b1_ctl.force_one) begin
            w_r = 33'd1;
        end else begin
            unique case (r_b1_ctl.mode)
                MODE_NONE:    w_r = r_b1_ctl.zero_out ? 33'd0 : w_x33;
                MODE_NEW_LOG: w_r = (r_b1_x <= w_hi) ? w_x33 : w_hi1;
                MODE_OLD_LOG: w_r = w_hi1;
                MODE_SQRT:    w_r = (r_b1_x <= r_scale_sq_hi) ? w_x33 + 33'd1 : w_hi1;
                default:      w_r = 33'd0;
            endcase
        end
        w_sat = (w_r > SAT_MAX) ? SAT_MAX : w_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_color <= w_sat[COUNT_BITS-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_color_index = r_color;

    // checks
    a_reset_empty : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid straight after reset");

    a_hold_front : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_s0_valid) && $stable(r_b1_valid))
        else $error("pipeline moved while held");

    a_force_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_b1_valid && r_b1_ctl.force_one) |=> (o_color_index == COUNT_BITS'(1)))
        else $error("offset region did not give colour one");

endmodule

`default_nettype wire

// File: verif/cmap_checker.sv
// ----------------------------------------------------------------------------
// cmap_checker
// Watches both channels of the colour map, predicts each palette index from
// the accepted count and the current register values, and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module cmap_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic        i_in_stall,
    input  wire logic [23:0] i_iter_count,
    input  wire logic        i_out_valid,
    input  wire logic        i_stall,
    input  wire logic [23:0] i_color_index,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cmap_pkg::*;

    t_mode       mode_q;
    logic        ranges_q;
    logic [23:0] offset_q;
    logic [31:0] scale_q;
    logic [23:0] colour_queue[$];

    function automatic logic [63:0] log2_fix(input logic [63:0] c);
        int n;
        logic [63:0] m, frac;
        n = 0;
        while (n < 31 && (c >> (n + 1)) != 0) n++;
        m = (c << (31 - n)) & 64'hFFFF_FFFF;
        frac = 0;
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(n) << 24) | frac;
    endfunction

    function automatic logic [63:0] ln_fix(input logic [63:0] c);
        return (log2_fix(c) * 64'(LN2_Q32)) >> 40;
    endfunction

    function automatic logic [63:0] sqrt_fix(input logic [63:0] c);
        logic [63:0] v, res, b;
        v = c << 32;
        res = 0;
        b = 64'd1 << 62;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [23:0] map_count(input logic [23:0] cnt);
        logic [63:0] c, l, s, r, d, lq;
        c = 64'(cnt);
        l = 64'(offset_q);
        s = 64'(scale_q);
        case (mode_q)
            MODE_NONE: r = ranges_q ? 64'd0 : c;
            MODE_NEW_LOG: begin
                if (c <= l + 1) begin
                    r = 1;
                end else begin
                    d = c - l;
                    lq = ln_fix(d);
                    if ((d << 32) <= s * lq) r = d;
                    else r = ((s * lq) >> 32) + 1;
                end
            end
            MODE_OLD_LOG: r = (c == 0) ? 64'd1 : ((s * ln_fix(c)) >> 32) + 1;
            default: begin
                if (c <= l) begin
                    r = 1;
                end else begin
                    d = c - l;
                    if (d <= ((s * s) >> 32)) r = d + 1;
                    else r = ((s * sqrt_fix(d)) >> 32) + 1;
                end
            end
        endcase
        return (r > 64'hFF_FFFF) ? 24'hFF_FFFF : r[23:0];
    endfunction

    assign o_pending = colour_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q <= MODE_NONE;
            ranges_q <= 1'b0;
            offset_q <= '0;
            scale_q <= '0;
            o_errors <= 0;
        end else begin
            if (i_out_valid && !i_stall) begin
                if (colour_queue.size() == 0) begin
                    if (o_errors < 10) $display("unexpected transfer: %h", i_color_index);
                    o_errors <= o_errors + 1;
                end else begin
                    logic [23:0] want;
                    want = colour_queue.pop_front();
                    if (want !== i_color_index) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %h got %h", want, i_color_index);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            // config only changes while idle, so current values apply
            if (i_valid && !i_in_stall) colour_queue.push_back(map_count(i_iter_count));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAP_MODE: mode_q <= t_mode'(i_cfg_data[1:0]);
                    REG_RANGES:   ranges_q <= i_cfg_data[0];
                    REG_OFFSET:   offset_q <= i_cfg_data[23:0];
                    default:      scale_q <= i_cfg_data;
                endcase
            end
        end
    end
endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the colour map through directed counts and random phases under
// several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cmap_pkg::*;

    logic        clk, rst_n, cfg_we, in_valid, in_stall, out_valid, out_stall;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;
    logic [23:0] iter_count, colour;
    int          errors, pending, cycles;
    bit          calm, hold_off;

    iteration_count_log_color_map_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .o_stall(in_stall),
        .i_iter_count(iter_count), .o_valid(out_valid), .i_stall(out_stall),
        .o_color_index(colour)
    );

    cmap_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_iter_count(iter_count), .i_out_valid(out_valid), .i_stall(out_stall),
        .i_color_index(colour), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, or one long hold-off on request
    initial begin
        int n;
        out_stall = 0;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1;
                repeat (120) @(posedge clk);
                hold_off = 0;
                out_stall <= 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                out_stall <= 1;
                repeat (n - 1) @(posedge clk);
            end else begin
                out_stall <= 0;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic send_count(input logic [23:0] c);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1;
        iter_count <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_count(input logic [23:0] offset);
        case ($urandom_range(0, 4))
            0: return 24'($urandom_range(0, 64));
            1: return offset + 24'($urandom_range(0, 8));
            2: return 24'($urandom_range(0, 4096));
            3: return 24'hFF_FFFF - 24'($urandom_range(0, 16));
            default: return 24'($urandom());
        endcase
    endfunction

    initial begin
        logic [1:0]  mode;
        logic [23:0] offset;
        logic [31:0] scale;
        rst_n = 0;
        cfg_we = 0;
        cfg_idx = '0;
        cfg_data = '0;
        in_valid = 0;
        iter_count = '0;
        calm = 0;
        hold_off = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;

        // directed: reset config passes counts through
        send_count(24'd0);
        send_count(24'd1);
        send_count(24'hFF_FFFF);
        drain();
        write_reg(REG_RANGES, 32'd1);
        send_count(24'd77);
        drain();
        write_reg(REG_RANGES, 32'd0);
        write_reg(REG_OFFSET, 32'd3);
        // zero scale in every compressing mode
        for (int m = 1; m < 4; m++) begin
            write_reg(REG_MAP_MODE, 32'(m));
            send_count(24'd0);
            send_count(24'd3);
            send_count(24'd4);
            send_count(24'd5);
            send_count(24'hFF_FFFF);
            drain();
        end
        // huge scale in every compressing mode
        write_reg(REG_SCALE, 32'hFFFF_FFFF);
        for (int m = 1; m < 4; m++) begin
            write_reg(REG_MAP_MODE, 32'(m));
            send_count(24'd2);
            send_count(24'd500);
            send_count(24'hFF_FFFF);
            drain();
        end

        // random phases
        for (int ph = 0; ph < 16; ph++) begin
            mode = 2'($urandom_range(0, 3));
            offset = (ph % 4 == 0) ? 24'hFF_FFFF : (ph % 4 == 1) ? 24'd0
                   : 24'($urandom_range(0, 300));
            case (ph % 3)
                0: scale = $urandom();
                1: scale = $urandom_range(0, 32'h40_0000);
                default: scale = (ph == 5) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 32'h2_0000));
            endcase
            write_reg(REG_MAP_MODE, 32'(mode));
            write_reg(REG_RANGES, 32'($urandom_range(0, 1)));
            write_reg(REG_OFFSET, 32'(offset) | ($urandom() & 32'hFF00_0000));
            write_reg(REG_SCALE, scale);
            calm = (ph >= 14);
            if (ph == 3) hold_off = 1;
            for (int k = 0; k < 95; k++) send_count(rand_count(offset));
            drain();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
